[src/svp_pkg.sv]
// Shared types, character codes, part codes and error codes for the
// semantic version string parser. No dependencies.
package svp_pkg;

    localparam int COUNT_LIMIT_DEF = 255;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [2:0] PART_MAJOR = 3'd0;
    localparam logic [2:0] PART_MINOR = 3'd1;
    localparam logic [2:0] PART_PATCH = 3'd2;
    localparam logic [2:0] PART_PRE   = 3'd3;
    localparam logic [2:0] PART_BUILD = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ERR_CORE_ZERO  = 3'd2;
    localparam logic [2:0] ERR_EMPTY_ID   = 3'd3;
    localparam logic [2:0] ERR_ID_ZERO    = 3'd4;
    localparam logic [2:0] ERR_CORE_RANGE = 3'd5;

    localparam logic [31:0] CORE_SAT = 32'h8000_0000;

    typedef struct packed {
        logic       dot;
        logic       dash;
        logic       plus;
        logic       digit;
        logic       zero;
        logic       id_ok;
        logic [3:0] digit_val;
    } t_char_class;

    typedef struct packed {
        logic [2:0]        part;
        logic [2:0][31:0]  core;
        logic [2:0]        core_empty;
        logic [1:0]        id_len;
        logic              id_first_zero;
        logic              id_all_digits;
        logic [2:0]        err;
    } t_state;

    localparam t_state STATE_INIT = '{
        part:          PART_MAJOR,
        core:          '0,
        core_empty:    3'b111,
        id_len:        2'd0,
        id_first_zero: 1'b0,
        id_all_digits: 1'b1,
        err:           ERR_NONE
    };

    typedef struct packed {
        logic [2:0]  part;
        logic        is_separator;
        logic [2:0]  error_code;
        logic        done_res;
        logic        valid_res;
        logic [30:0] major;
        logic [30:0] minor;
        logic [30:0] patch;
        logic [7:0]  prerelease_ids;
        logic [7:0]  build_ids;
    } t_result;

endpackage

[src/svp_classify.sv]
// Byte classifier: separators, digits and identifier characters.
// Depends on svp_pkg.
module svp_classify
    import svp_pkg::*;
(
    input  logic [7:0]  i_ch,
    output t_char_class o_cls
);

    logic [7:0] digit_off;

    assign digit_off = i_ch - CH_ZERO;

    always_comb begin
        o_cls.dot       = (i_ch == CH_DOT);
        o_cls.dash      = (i_ch == CH_DASH);
        o_cls.plus      = (i_ch == CH_PLUS);
        o_cls.digit     = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        o_cls.zero      = (i_ch == CH_ZERO);
        o_cls.id_ok     = o_cls.digit
                        || ((i_ch >= CH_UP_A) && (i_ch <= CH_UP_Z))
                        || ((i_ch >= CH_LO_A) && (i_ch <= CH_LO_Z))
                        || o_cls.dash;
        o_cls.digit_val = digit_off[3:0];
    end

endmodule

[src/svp_next.sv]
// Next-state and result logic for one byte of the version string.
// Depends on svp_pkg; fed by svp_classify.
module svp_next
    import svp_pkg::*;
#(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
    localparam int CW = $clog2(COUNT_LIMIT + 1)
) (
    input  t_state      i_state,
    input  logic [CW-1:0] i_pre_cnt,
    input  logic [CW-1:0] i_bld_cnt,
    input  t_char_class i_cls,
    input  logic        i_last,
    output t_state      o_state,
    output logic [CW-1:0] o_pre_cnt,
    output logic [CW-1:0] o_bld_cnt,
    output t_result     o_res
);

    localparam logic [CW-1:0] LIMIT = CW'(COUNT_LIMIT);

    always_comb begin
        t_state          n;
        logic [CW-1:0]   pc;
        logic [CW-1:0]   bc;
        logic            sep;
        logic            do_close;
        logic            close_pre;
        logic            take_core;
        logic            take_id;
        logic [1:0]      idx;
        logic [31:0]     cv;
        logic [35:0]     prod;
        logic [2:0]      part_out;
        logic            valid;
        logic [CW+7:0]   pc_ext;
        logic [CW+7:0]   bc_ext;

        n         = i_state;
        pc        = i_pre_cnt;
        bc        = i_bld_cnt;
        sep       = 1'b0;
        do_close  = 1'b0;
        close_pre = 1'b0;
        take_core = 1'b0;
        take_id   = 1'b0;
        idx       = i_state.part[1:0];
        cv        = i_state.core[idx];
        prod      = ({4'd0, cv} << 3) + ({4'd0, cv} << 1) + {32'd0, i_cls.digit_val};

        unique case (i_state.part) inside
            PART_MAJOR, PART_MINOR: begin
                if (i_cls.dot) begin
                    n.part = i_state.part + 3'd1;
                    sep    = 1'b1;
                end else begin
                    take_core = 1'b1;
                end
            end
            PART_PATCH: begin
                if (i_cls.dash) begin
                    n.part = PART_PRE;
                    sep    = 1'b1;
                end else if (i_cls.plus) begin
                    n.part = PART_BUILD;
                    sep    = 1'b1;
                end else begin
                    take_core = 1'b1;
                end
            end
            PART_PRE: begin
                if (i_cls.dot) begin
                    do_close  = 1'b1;
                    close_pre = 1'b1;
                    sep       = 1'b1;
                end else if (i_cls.plus) begin
                    do_close  = 1'b1;
                    close_pre = 1'b1;
                    n.part    = PART_BUILD;
                    sep       = 1'b1;
                end else begin
                    take_id = 1'b1;
                end
            end
            default: begin
                if (i_cls.dot) begin
                    do_close = 1'b1;
                    sep      = 1'b1;
                end else begin
                    take_id = 1'b1;
                end
            end
        endcase

        if (take_core) begin
            if (!i_cls.digit) begin
                if (n.err == ERR_NONE) n.err = ERR_BAD_CHAR;
            end else if (!i_state.core_empty[idx] && (cv == 32'd0)) begin
                if (n.err == ERR_NONE) n.err = ERR_CORE_ZERO;
            end else begin
                n.core[idx]       = (prod > {4'd0, CORE_SAT}) ? CORE_SAT : prod[31:0];
                n.core_empty[idx] = 1'b0;
            end
        end

        if (take_id) begin
            if (!i_cls.id_ok) begin
                if (n.err == ERR_NONE) n.err = ERR_BAD_CHAR;
            end else begin
                if (n.id_len == 2'd0) n.id_first_zero = i_cls.zero;
                if (!i_cls.digit) n.id_all_digits = 1'b0;
                if (n.id_len < 2'd2) n.id_len = n.id_len + 2'd1;
            end
        end

        if (do_close) begin
            if (n.id_len == 2'd0) begin
                if (n.err == ERR_NONE) n.err = ERR_EMPTY_ID;
            end else if (close_pre && n.id_all_digits && n.id_first_zero
                         && (n.id_len >= 2'd2)) begin
                if (n.err == ERR_NONE) n.err = ERR_ID_ZERO;
            end else if (close_pre) begin
                pc = (pc >= LIMIT) ? LIMIT : pc + CW'(1);
            end else begin
                bc = (bc >= LIMIT) ? LIMIT : bc + CW'(1);
            end
            n.id_len        = 2'd0;
            n.id_first_zero = 1'b0;
            n.id_all_digits = 1'b1;
        end

        part_out = n.part;

        if (i_last && ((n.part == PART_PRE) || (n.part == PART_BUILD))) begin
            if (n.id_len == 2'd0) begin
                if (n.err == ERR_NONE) n.err = ERR_EMPTY_ID;
            end else if ((n.part == PART_PRE) && n.id_all_digits && n.id_first_zero
                         && (n.id_len >= 2'd2)) begin
                if (n.err == ERR_NONE) n.err = ERR_ID_ZERO;
            end else if (n.part == PART_PRE) begin
                pc = (pc >= LIMIT) ? LIMIT : pc + CW'(1);
            end else begin
                bc = (bc >= LIMIT) ? LIMIT : bc + CW'(1);
            end
        end

        if (i_last) begin
            for (int i = 0; i < 3; i++) begin
                if (n.core_empty[i] || n.core[i][31]) begin
                    if (n.err == ERR_NONE) n.err = ERR_CORE_RANGE;
                end
            end
        end

        valid  = i_last && (n.err == ERR_NONE);
        pc_ext = {8'd0, pc};
        bc_ext = {8'd0, bc};

        o_res.part           = part_out;
        o_res.is_separator   = sep;
        o_res.error_code     = n.err;
        o_res.done_res       = i_last;
        o_res.valid_res      = valid;
        o_res.major          = valid ? n.core[0][30:0] : 31'd0;
        o_res.minor          = valid ? n.core[1][30:0] : 31'd0;
        o_res.patch          = valid ? n.core[2][30:0] : 31'd0;
        o_res.prerelease_ids = valid ? pc_ext[7:0] : 8'd0;
        o_res.build_ids      = valid ? bc_ext[7:0] : 8'd0;

        if (i_last) begin
            o_state   = STATE_INIT;
            o_pre_cnt = '0;
            o_bld_cnt = '0;
        end else begin
            o_state   = n;
            o_pre_cnt = pc;
            o_bld_cnt = bc;
        end
    end

endmodule

[src/semantic_version_string_parser.sv]
// Semantic version string parser, one byte per beat, one result beat per byte.
// A byte waits in the input stage and its result is registered in r_res.
// Throughput: one byte per cycle unless i_ready stalls the output; the parse
// state feeds back through one step. Reset (synchronous, active low) empties
// both stages; it and a last byte return the parse state to the major number.
module semantic_version_string_parser
    import svp_pkg::*;
#(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
    localparam int CW = $clog2(COUNT_LIMIT + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_part,
    output logic        o_is_separator,
    output logic [2:0]  o_error_code,
    output logic        o_done_res,
    output logic        o_valid_res,
    output logic [30:0] o_major,
    output logic [30:0] o_minor,
    output logic [30:0] o_patch,
    output logic [7:0]  o_prerelease_ids,
    output logic [7:0]  o_build_ids
);

    logic          r_in_valid;
    logic [7:0]    r_ch;
    logic          r_last;
    logic          r_out_valid;
    t_result       r_res;
    t_state        r_state;
    logic [CW-1:0] r_pre_cnt;
    logic [CW-1:0] r_bld_cnt;

    t_char_class   cls;
    t_state        n_state;
    logic [CW-1:0] n_pre_cnt;
    logic [CW-1:0] n_bld_cnt;
    t_result       n_res;
    logic          adv;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    svp_classify u_classify (
        .i_ch  (r_ch),
        .o_cls (cls)
    );

    svp_next #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_next (
        .i_state   (r_state),
        .i_pre_cnt (r_pre_cnt),
        .i_bld_cnt (r_bld_cnt),
        .i_cls     (cls),
        .i_last    (r_last),
        .o_state   (n_state),
        .o_pre_cnt (n_pre_cnt),
        .o_bld_cnt (n_bld_cnt),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_INIT;
            r_pre_cnt   <= '0;
            r_bld_cnt   <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_pre_cnt   <= n_pre_cnt;
                r_bld_cnt   <= n_bld_cnt;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_part           = r_res.part;
    assign o_is_separator   = r_res.is_separator;
    assign o_error_code     = r_res.error_code;
    assign o_done_res       = r_res.done_res;
    assign o_valid_res      = r_res.valid_res;
    assign o_major          = r_res.major;
    assign o_minor          = r_res.minor;
    assign o_patch          = r_res.patch;
    assign o_prerelease_ids = r_res.prerelease_ids;
    assign o_build_ids      = r_res.build_ids;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_last |=> (r_state.part == PART_MAJOR) && (r_state.err == ERR_NONE)
            && (r_state.core_empty == 3'b111) && (r_pre_cnt == '0) && (r_bld_cnt == '0))
        else $error("parse state not cleared after last byte");

    a_valid_implies_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_done_res && (o_error_code == ERR_NONE))
        else $error("valid result without done or with error");

    a_not_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> !o_valid_res && (o_major == 31'd0)
            && (o_prerelease_ids == 8'd0) && (o_build_ids == 8'd0))
        else $error("numbers shown on a result that is not done");

    a_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_ch) && $stable(r_last))
        else $error("input stage lost a stalled byte");
`endif

endmodule

[tb/sv/semantic_version_string_parser_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for semantic_version_string_parser: drives version strings
// byte by byte, checking each result beat against a built-in predictor or, for
// directed last bytes, a fixed result. Depends on svp_pkg and the parser RTL only.
module semantic_version_string_parser_tb;
    import svp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 320;
    localparam int DIR_ROWS       = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       drain;
        logic       typed;
        t_result    want;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_ch = 8'h00;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_part;
    logic        o_is_separator;
    logic [2:0]  o_error_code;
    logic        o_done_res;
    logic        o_valid_res;
    logic [30:0] o_major;
    logic [30:0] o_minor;
    logic [30:0] o_patch;
    logic [7:0]  o_prerelease_ids;
    logic [7:0]  o_build_ids;

    semantic_version_string_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_ch             (i_ch),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_part           (o_part),
        .o_is_separator   (o_is_separator),
        .o_error_code     (o_error_code),
        .o_done_res       (o_done_res),
        .o_valid_res      (o_valid_res),
        .o_major          (o_major),
        .o_minor          (o_minor),
        .o_patch          (o_patch),
        .o_prerelease_ids (o_prerelease_ids),
        .o_build_ids      (o_build_ids)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // parse state mirror
    logic [2:0]       p_part;
    logic [2:0][31:0] p_core;
    logic [2:0]       p_core_none;
    logic [1:0]       p_id_len;
    logic             p_id_zero;
    logic             p_id_digits;
    logic [2:0]       p_err;
    int               p_pre_ids;
    int               p_build_ids;

    t_beat      byte_q[$];
    t_result    result_q[$];
    logic [7:0] scratch[$];
    t_beat      on_bus;

    int faults = 0;
    int res_count = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_tick = 0;
    logic [7:0] rx_mask = 8'h01;

    string   dir_text [DIR_ROWS] = '{"0.0.0", "1.2.3-a.0+01", "01", "1.x.00", "1.1.1-00",
                                     "1.1.1+", "\377", "5.4"};
    bit      [DIR_ROWS-1:0] dir_typed = 8'b1111_1101;
    t_result dir_want [DIR_ROWS];

    function automatic void put_byte(logic [7:0] c);
        scratch.insert(scratch.size(), c);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_id_char(logic [7:0] c);
        return is_num(c) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_DASH;
    endfunction

    function automatic void flag(logic [2:0] code);
        if (p_err == ERR_NONE) p_err = code;
    endfunction

    function automatic void clear_ident();
        p_id_len = 2'd0;
        p_id_zero = 1'b0;
        p_id_digits = 1'b1;
    endfunction

    function automatic void clear_version();
        p_part = PART_MAJOR;
        p_core = '0;
        p_core_none = 3'b111;
        clear_ident();
        p_err = ERR_NONE;
        p_pre_ids = 0;
        p_build_ids = 0;
    endfunction

    function automatic void end_ident(bit pre);
        if (p_id_len == 2'd0) begin
            flag(ERR_EMPTY_ID);
        end else if (pre && p_id_digits && p_id_zero && p_id_len >= 2'd2) begin
            flag(ERR_ID_ZERO);
        end else if (pre) begin
            p_pre_ids = (p_pre_ids >= COUNT_LIMIT_DEF) ? COUNT_LIMIT_DEF : p_pre_ids + 1;
        end else begin
            p_build_ids = (p_build_ids >= COUNT_LIMIT_DEF) ? COUNT_LIMIT_DEF : p_build_ids + 1;
        end
        clear_ident();
    endfunction

    function automatic void add_ident_char(logic [7:0] c);
        if (!is_id_char(c)) begin
            flag(ERR_BAD_CHAR);
        end else begin
            if (p_id_len == 2'd0) p_id_zero = (c == CH_ZERO);
            if (!is_num(c)) p_id_digits = 1'b0;
            if (p_id_len < 2'd2) p_id_len = p_id_len + 2'd1;
        end
    endfunction

    function automatic void add_core_digit(int idx, logic [7:0] c);
        logic [63:0] acc;
        if (!is_num(c)) begin
            flag(ERR_BAD_CHAR);
        end else if (!p_core_none[idx] && p_core[idx] == '0) begin
            flag(ERR_CORE_ZERO);
        end else begin
            acc = 64'(p_core[idx]) * 64'd10 + 64'(c - CH_ZERO);
            if (acc > 64'(CORE_SAT)) acc = 64'(CORE_SAT);
            p_core[idx] = acc[31:0];
            p_core_none[idx] = 1'b0;
        end
    endfunction

    function automatic t_result parse_byte(logic [7:0] c, logic lst);
        t_result r;
        r = '0;
        case (p_part) inside
            PART_MAJOR, PART_MINOR: begin
                if (c == CH_DOT) begin
                    p_part = p_part + 3'd1;
                    r.is_separator = 1'b1;
                end else begin
                    add_core_digit(p_part, c);
                end
            end
            PART_PATCH: begin
                if (c == CH_DASH) begin
                    p_part = PART_PRE;
                    r.is_separator = 1'b1;
                end else if (c == CH_PLUS) begin
                    p_part = PART_BUILD;
                    r.is_separator = 1'b1;
                end else begin
                    add_core_digit(2, c);
                end
            end
            PART_PRE: begin
                if (c == CH_DOT) begin
                    end_ident(1'b1);
                    r.is_separator = 1'b1;
                end else if (c == CH_PLUS) begin
                    end_ident(1'b1);
                    p_part = PART_BUILD;
                    r.is_separator = 1'b1;
                end else begin
                    add_ident_char(c);
                end
            end
            default: begin
                if (c == CH_DOT) begin
                    end_ident(1'b0);
                    r.is_separator = 1'b1;
                end else begin
                    add_ident_char(c);
                end
            end
        endcase
        r.part = p_part;
        if (lst) begin
            if (p_part == PART_PRE) end_ident(1'b1);
            else if (p_part == PART_BUILD) end_ident(1'b0);
            for (int i = 0; i < 3; i++) begin
                if (p_core_none[i] || p_core[i] >= CORE_SAT) flag(ERR_CORE_RANGE);
            end
            r.done_res = 1'b1;
            r.valid_res = (p_err == ERR_NONE);
            if (r.valid_res) begin
                r.major = p_core[0][30:0];
                r.minor = p_core[1][30:0];
                r.patch = p_core[2][30:0];
                r.prerelease_ids = p_pre_ids[7:0];
                r.build_ids = p_build_ids[7:0];
            end
        end
        r.error_code = p_err;
        if (lst) clear_version();
        return r;
    endfunction

    function automatic t_result ends_with(logic [2:0] part, logic sep, logic [2:0] err);
        t_result r;
        r = '0;
        r.part = part;
        r.is_separator = sep;
        r.error_code = err;
        r.done_res = 1'b1;
        r.valid_res = (err == ERR_NONE);
        return r;
    endfunction

    function automatic void queue_string(bit drain, bit typed, t_result want);
        t_beat b;
        foreach (scratch[i]) begin
            b = '0;
            b.ch = scratch[i];
            b.last = (i == scratch.size() - 1);
            b.drain = drain && (i == 0);
            b.typed = typed && b.last;
            b.want = want;
            byte_q.insert(byte_q.size(), b);
        end
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return CH_DOT;
            3: return CH_DASH;
            4: return CH_PLUS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_number();
        logic [31:0] n;
        string dec;
        case ($urandom_range(0, 9))
            0: n = '0;
            1: n = CORE_SAT - 32'd1;
            2: n = CORE_SAT;
            3: n = $urandom;
            default: n = $urandom_range(0, 99);
        endcase
        if ($urandom_range(0, 19) == 0) put_byte(CH_ZERO);
        if ($urandom_range(0, 29) == 0) return;
        dec = $sformatf("%0d", n);
        for (int k = 0; k < dec.len(); k++) put_byte(dec[k]);
    endfunction

    function automatic void add_idents(int count);
        string pool;
        int len;
        for (int j = 0; j < count; j++) begin
            if (j > 0) put_byte(CH_DOT);
            pool = ($urandom_range(0, 2) == 0) ? "00123456789" :
                   "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-";
            len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
            for (int k = 0; k < len; k++) put_byte(pool[$urandom_range(0, pool.len() - 1)]);
        end
    endfunction

    function automatic void make_string();
        int len;
        scratch.delete();
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) put_byte(noise_byte());
            return;
        end
        add_number();
        put_byte(CH_DOT);
        add_number();
        put_byte(CH_DOT);
        add_number();
        if ($urandom_range(0, 1) == 1) begin
            put_byte(CH_DASH);
            add_idents($urandom_range(1, 3));
        end
        if ($urandom_range(0, 2) == 0) begin
            put_byte(CH_PLUS);
            add_idents($urandom_range(1, 3));
        end
        if ($urandom_range(0, 4) == 0) scratch[$urandom_range(0, scratch.size() - 1)] = noise_byte();
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, scratch.size() - 1)) scratch.pop_back();
    endfunction

    function automatic void fill_ids(int count, logic [7:0] c);
        for (int k = 0; k < count; k++) begin
            if (k > 0) put_byte(CH_DOT);
            put_byte(c);
        end
    endfunction

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            faults++;
            if (faults <= 10)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         label, res_count, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        bit      sent;
        if (!i_rst_n) begin
            clear_version();
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_part, o_is_separator, o_error_code, o_done_res, o_valid_res,
                       o_major, o_minor, o_patch, o_prerelease_ids, o_build_ids};
                if (result_q.size() == 0) begin
                    faults++;
                    if (faults <= 10) $display("result %0d arrived with nothing expected", res_count);
                end else begin
                    want = result_q.pop_front();
                    check_field("part", want.part, got.part);
                    check_field("is_separator", want.is_separator, got.is_separator);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("valid_res", want.valid_res, got.valid_res);
                    check_field("major", want.major, got.major);
                    check_field("minor", want.minor, got.minor);
                    check_field("patch", want.patch, got.patch);
                    check_field("prerelease_ids", want.prerelease_ids, got.prerelease_ids);
                    check_field("build_ids", want.build_ids, got.build_ids);
                end
                res_count++;
            end

            sent = i_valid && o_ready;
            if (sent) begin
                want = parse_byte(i_ch, i_last);
                if (on_bus.typed) want = on_bus.want;
                result_q.insert(result_q.size(), want);
            end

            if (sent || !i_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (byte_q.size() == 0 ||
                             (byte_q[0].drain && result_q.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    on_bus = byte_q.pop_front();
                    i_ch <= on_bus.ch;
                    i_last <= on_bus.last;
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 7)) inside
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(8, 15);
                            default: gap_left = $urandom_range(1, 5);
                        endcase
                    end
                end
            end

            if (rx_tick == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mask = 8'($urandom_range(1, 255));
                rx_tick = $urandom_range(20, 80);
            end else begin
                rx_tick--;
            end
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    rx_mask = {rx_mask[6:0], rx_mask[7]};
                    i_ready <= rx_mask[0];
                end
            endcase

            if (sent || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int goal;
        int strings;
        dir_want[0] = ends_with(PART_PATCH, 1'b0, ERR_NONE);
        dir_want[1] = '0;
        dir_want[2] = ends_with(PART_MAJOR, 1'b0, ERR_CORE_ZERO);
        dir_want[3] = ends_with(PART_PATCH, 1'b0, ERR_BAD_CHAR);
        dir_want[4] = ends_with(PART_PRE, 1'b0, ERR_ID_ZERO);
        dir_want[5] = ends_with(PART_BUILD, 1'b1, ERR_EMPTY_ID);
        dir_want[6] = ends_with(PART_MAJOR, 1'b0, ERR_BAD_CHAR);
        dir_want[7] = ends_with(PART_MINOR, 1'b0, ERR_CORE_RANGE);
        for (int r = 0; r < DIR_ROWS; r++) begin
            scratch.delete();
            for (int k = 0; k < dir_text[r].len(); k++) put_byte(dir_text[r][k]);
            queue_string(1'b0, dir_typed[r], dir_want[r]);
        end

        goal = byte_q.size() + RANDOM_BYTES;
        strings = 0;
        while (byte_q.size() < goal) begin
            make_string();
            queue_string(strings % 12 == 0, 1'b0, '0);
            strings++;
        end

        // saturate the pre-release identifier count
        scratch.delete();
        repeat (2) begin
            put_byte(CH_ZERO);
            put_byte(CH_DOT);
        end
        put_byte(CH_ZERO);
        put_byte(CH_DASH);
        fill_ids(COUNT_LIMIT_DEF + 2, CH_NINE);
        put_byte(CH_PLUS);
        fill_ids(2, CH_UP_A);
        queue_string(1'b1, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (byte_q.size() != 0 || i_valid || result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (faults == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[semantic_version_string_parser.f]
src/svp_pkg.sv
src/svp_classify.sv
src/svp_next.sv
src/semantic_version_string_parser.sv
tb/sv/semantic_version_string_parser_tb.sv
